@@ sv/utf8_validate_replace_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_REPLACE_DEFINES_SVH
`define UTF8_VALIDATE_REPLACE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define UV_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define UV_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/utf8vr_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: package
// Run descriptor type, byte class constants and the well-formed table helpers.
// ----------------------------------------------------------------------------
package utf8vr_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RUN             = 4;

   localparam logic [7:0] REPL_RESET    = 8'h3F;
   localparam logic [7:0] ASCII_LIMIT   = 8'h80;
   localparam logic [7:0] CONT_LO       = 8'h80;
   localparam logic [7:0] CONT_HI       = 8'hBF;
   localparam logic [7:0] LEAD2_LO      = 8'hC2;
   localparam logic [7:0] LEAD2_HI      = 8'hDF;
   localparam logic [7:0] LEAD3_LO      = 8'hE0;
   localparam logic [7:0] LEAD3_HI      = 8'hEF;
   localparam logic [7:0] LEAD4_LO      = 8'hF0;
   localparam logic [7:0] LEAD4_HI      = 8'hF4;
   localparam logic [7:0] LEAD_E0       = 8'hE0;
   localparam logic [7:0] LEAD_ED       = 8'hED;
   localparam logic [7:0] LEAD_F0       = 8'hF0;
   localparam logic [7:0] LEAD_F4       = 8'hF4;
   localparam logic [7:0] AFTER_E0_LO   = 8'hA0;
   localparam logic [7:0] AFTER_ED_HI   = 8'h9F;
   localparam logic [7:0] AFTER_F0_LO   = 8'h90;
   localparam logic [7:0] AFTER_F4_HI   = 8'h8F;

   // Register index of the replacement byte
   localparam logic REG_REPL = 1'b0;

   // One step's worth of results, packed for the queue
   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] bytes;   // result bytes, first in entry 0
      logic [MAX_RUN-1:0]      repl;    // replaced flag per result
      logic [1:0]              last;    // index of the last result
      logic                    eos;     // step closed the string
   } run_type;

   // Queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Sequence length of a lead byte, zero when not a valid multi-byte lead
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b inside {[LEAD2_LO:LEAD2_HI]}) len = 3'd2;
      else if (b inside {[LEAD3_LO:LEAD3_HI]}) len = 3'd3;
      else if (b inside {[LEAD4_LO:LEAD4_HI]}) len = 3'd4;
      return len;
   endfunction

   // Continuation check; the second byte range narrows after some leads
   function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_LO;
      hi = CONT_HI;
      if (pos == 2'd1) begin
         if (lead == LEAD_E0) lo = AFTER_E0_LO;
         else if (lead == LEAD_ED) hi = AFTER_ED_HI;
         else if (lead == LEAD_F0) lo = AFTER_F0_LO;
         else if (lead == LEAD_F4) hi = AFTER_F4_HI;
      end
      return (b >= lo) && (b <= hi);
   endfunction

endpackage

@@ sv/utf8vr_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: front end
// Accepts bytes, tracks the open sequence and pushes one run per deciding step.
// ----------------------------------------------------------------------------
module utf8vr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [7:0]                  in_byte,
   input  logic                        end_of_string,
   input  logic [7:0]                  repl_byte,
   input  utf8vr_pkg::q_status_type    q_status,
   output logic                        push,
   output utf8vr_pkg::run_type         run
);
   import utf8vr_pkg::*;

   logic [1:0]       held_count_ff;
   logic [1:0]       held_count_in;
   logic [2:0][7:0]  held_ff;
   logic [2:0][7:0]  held_in;
   logic [2:0]       n_emit;
   logic [2:0]       need;
   logic             rejudge;
   logic             accept;
   run_type          run_in;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   // Judge the byte against the open sequence and collect its results
   always_comb begin
      run_in        = '0;
      n_emit        = 3'd0;
      held_count_in = held_count_ff;
      held_in       = held_ff;
      need          = lead_len(held_ff[0]);
      rejudge       = 1'b0;

      if (held_count_ff == 2'd0) begin
         rejudge = 1'b1;
      end else if (need != 3'd0 && cont_ok(held_ff[0], held_count_ff, in_byte)) begin
         if ({1'b0, held_count_ff} + 3'd1 >= need) begin
            // Sequence complete: release the held bytes and this one
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < held_count_ff) begin
                  run_in.bytes[n_emit[1:0]] = held_ff[i];
                  n_emit = n_emit + 3'd1;
               end
            end
            run_in.bytes[n_emit[1:0]] = in_byte;
            n_emit        = n_emit + 3'd1;
            held_count_in = 2'd0;
         end else begin
            held_in[held_count_ff] = in_byte;
            held_count_in          = held_count_ff + 2'd1;
         end
      end else begin
         // Broken sequence: replace what was held, then retry as a lead
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_count_ff) begin
               run_in.bytes[n_emit[1:0]] = repl_byte;
               run_in.repl[n_emit[1:0]]  = 1'b1;
               n_emit = n_emit + 3'd1;
            end
         end
         held_count_in = 2'd0;
         rejudge       = 1'b1;
      end

      if (rejudge) begin
         if (in_byte < ASCII_LIMIT) begin
            run_in.bytes[n_emit[1:0]] = in_byte;
            n_emit = n_emit + 3'd1;
         end else if (lead_len(in_byte) != 3'd0) begin
            held_in[0]    = in_byte;
            held_count_in = 2'd1;
         end else begin
            run_in.bytes[n_emit[1:0]] = repl_byte;
            run_in.repl[n_emit[1:0]]  = 1'b1;
            n_emit = n_emit + 3'd1;
         end
      end

      // Flush anything still open at the end of the string
      if (end_of_string) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_count_in) begin
               run_in.bytes[n_emit[1:0]] = repl_byte;
               run_in.repl[n_emit[1:0]]  = 1'b1;
               n_emit = n_emit + 3'd1;
            end
         end
         held_count_in = 2'd0;
      end

      run_in.last = n_emit[1:0] - 2'd1;
      run_in.eos  = end_of_string;
   end

   assign push = accept && (n_emit != 3'd0);
   assign run  = run_in;

   // Advance the sequence state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

@@ sv/utf8vr_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: run queue
// Small register FIFO of run descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`include "utf8_validate_replace_defines.svh"

module utf8vr_queue #(
   parameter int DEPTH = utf8vr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  utf8vr_pkg::run_type       push_run,
   input  logic                      pop,
   output utf8vr_pkg::run_type       head,
   output utf8vr_pkg::q_status_type  status
);
   import utf8vr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   run_type           store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head         = store_ff[rd_ptr_ff];

   // Step pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_run;
      end
   end

   `UV_ASSERT_ALWAYS(a_no_overflow, !(push && status.full), "run pushed into full queue")
   `UV_ASSERT_ALWAYS(a_no_underflow, !(pop && status.empty), "run popped from empty queue")
   `UV_ASSERT_ALWAYS(a_count_range, count_ff <= CNT_FULL, "queue fill beyond depth")

endmodule

@@ sv/utf8vr_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: back end
// Takes runs from the queue and hands out their bytes one item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "utf8_validate_replace_defines.svh"

module utf8vr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  utf8vr_pkg::run_type       head,
   input  utf8vr_pkg::q_status_type  q_status,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_byte,
   output logic                      was_replaced,
   output logic                      end_of_run,
   output logic                      string_done
);
   import utf8vr_pkg::*;

   run_type     desc_ff;
   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   logic        busy_ff;
   logic        busy_in;
   logic        last;
   logic        taken;

   assign last  = (idx_ff == desc_ff.last);
   assign taken = busy_ff && out_ready;
   assign pop   = !q_status.empty && (!busy_ff || (taken && last));

   assign out_valid    = busy_ff;
   assign out_byte     = desc_ff.bytes[idx_ff];
   assign was_replaced = desc_ff.repl[idx_ff];
   assign end_of_run   = last;
   assign string_done  = last && desc_ff.eos;

   // Step through the run, loading the next one as the last item goes
   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop) begin
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (taken) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         desc_ff <= head;
      end
   end

   `UV_ASSERT_ALWAYS(a_idx_in_run, !busy_ff || idx_ff <= desc_ff.last, "index past run end")
   `UV_ASSERT_ALWAYS(a_done_is_last, !(out_valid && string_done) || end_of_run,
      "string end not on run end")
   `UV_ASSERT_NEXT(a_drain_idle, taken && last && q_status.empty, !busy_ff,
      "back end busy with no run loaded")

endmodule

@@ sv/utf8_validate_replace.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: top level
// Checks a byte stream against the well-formed UTF-8 table and replaces
// every rejected byte with a configurable byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one string byte per item, req_tlast on the last byte.
//   rsp_* carries result bytes; rsp_tlast closes the results of one input
//   item and rsp_tuser[1] marks the final result of the string.
//   An input item gives zero to four results: bytes of an open sequence are
//   held until it completes or fails, so there are no results for them yet.
//   The front end takes one byte per cycle while the run queue has room; the
//   back end sends one result per cycle while rsp_tready is high. The
//   results of a deciding byte are written into the run queue, then loaded
//   into the back end's run register, from which they are sent.
//   A stalled receiver fills the run queue (QUEUE_DEPTH runs), after which
//   req_tready drops until the back end frees an entry.
//   Reset drops any open sequence, empties the queue and sets the
//   replacement byte to a question mark. Write csr register 0 only when
//   the block is idle.
// ----------------------------------------------------------------------------
module utf8_validate_replace #(
   parameter int QUEUE_DEPTH = utf8vr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] in_byte
   input  logic         req_tlast,     // end_of_string
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,     // [7:0] out_byte
   output logic [1:0]   rsp_tuser,     // [0] was_replaced, [1] string_done
   output logic         rsp_tlast,     // end_of_run
   // configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import utf8vr_pkg::*;

   logic [7:0]    repl_ff;
   logic          csr_wr;
   logic          push;
   logic          pop;
   logic          was_replaced;
   logic          string_done;
   run_type       push_run;
   run_type       head;
   q_status_type  q_status;

   // Replacement byte register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_REPL) ? {24'd0, repl_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_REPL) begin
         repl_ff <= csr_pwdata[7:0];
      end
   end

   utf8vr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_byte       (req_tdata),
      .end_of_string (req_tlast),
      .repl_byte     (repl_ff),
      .q_status      (q_status),
      .push          (push),
      .run           (push_run)
   );

   utf8vr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   utf8vr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .was_replaced (was_replaced),
      .end_of_run   (rsp_tlast),
      .string_done  (string_done)
   );

   assign rsp_tuser = {string_done, was_replaced};

endmodule

@@ verif/tb_utf8_validate_replace.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and replace: testbench
// Drives byte strings into the validator and checks every result byte against
// a scoreboard that tracks the open sequence itself. A directed set covers
// range edges, narrowed second bytes and failure cases, then random strings of
// mostly well-formed characters run under several replacement bytes, with
// bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_utf8_validate_replace;

   localparam logic [2:0] REPL_ADDR     = 3'd0;    // replacement byte register
   localparam logic [2:0] SPARE_ADDR    = 3'd4;    // unmapped, writes ignored
   localparam int         PHASE_ITEMS   = 42;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         DRAIN_CYCLES  = 16;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         REPORT_MAX    = 10;

   typedef logic [7:0] byte_q_type[$];

   // One result item as the block should present it
   typedef struct packed {
      logic [7:0] out_byte;
      logic       was_replaced;
      logic       end_of_run;
      logic       string_done;
   } utf8_result_type;

   // Tracks the open sequence and holds the result items still to come
   class utf8_expect_board;
      utf8_result_type pending_q[$];
      utf8_result_type step_q[$];
      logic [7:0]      repl_byte;
      logic [7:0]      held[3];
      int              held_n;
      int              mismatches;
      int              checked;
      int              replaced_seen;

      function new();
         repl_byte     = 8'h3F;
         held_n        = 0;
         mismatches    = 0;
         checked       = 0;
         replaced_seen = 0;
      endfunction

      // Only the replacement byte register exists; keep its low 8 bits
      function void apply_write(logic [2:0] addr, logic [31:0] data);
         if (addr == REPL_ADDR) repl_byte = data[7:0];
      endfunction

      function int seq_length(logic [7:0] b);
         if (b >= 8'hC2 && b <= 8'hDF) return 2;
         if (b >= 8'hE0 && b <= 8'hEF) return 3;
         if (b >= 8'hF0 && b <= 8'hF4) return 4;
         return 0;
      endfunction

      // Second byte ranges narrow after E0, ED, F0 and F4
      function bit cont_in_range(logic [7:0] lead, int pos, logic [7:0] b);
         logic [7:0] lo;
         logic [7:0] hi;
         lo = 8'h80;
         hi = 8'hBF;
         if (pos == 1) begin
            if (lead == 8'hE0) lo = 8'hA0;
            else if (lead == 8'hED) hi = 8'h9F;
            else if (lead == 8'hF0) lo = 8'h90;
            else if (lead == 8'hF4) hi = 8'h8F;
         end
         return (b >= lo) && (b <= hi);
      endfunction

      function void emit(logic [7:0] b, logic repl);
         utf8_result_type r;
         r.out_byte     = b;
         r.was_replaced = repl;
         r.end_of_run   = 1'b0;
         r.string_done  = 1'b0;
         step_q.push_back(r);
      endfunction

      function void flush_held();
         for (int i = 0; i < held_n; i++) emit(repl_byte, 1'b1);
         held_n = 0;
      endfunction

      function void take_lead(logic [7:0] b);
         if (b < 8'h80) begin
            emit(b, 1'b0);
         end else if (seq_length(b) != 0) begin
            held[0] = b;
            held_n  = 1;
         end else begin
            emit(repl_byte, 1'b1);
         end
      endfunction

      function void judge_byte(logic [7:0] b);
         int need;
         if (held_n == 0) begin
            take_lead(b);
            return;
         end
         need = seq_length(held[0]);
         if (cont_in_range(held[0], held_n, b)) begin
            if (held_n + 1 >= need) begin
               for (int i = 0; i < held_n; i++) emit(held[i], 1'b0);
               emit(b, 1'b0);
               held_n = 0;
            end else begin
               held[held_n] = b;
               held_n++;
            end
         end else begin
            // broken sequence: release held bytes replaced, retry the byte as a lead
            flush_held();
            take_lead(b);
         end
      endfunction

      // Work out the results of one accepted input item
      function void note_item(logic [7:0] b, logic eos);
         step_q = {};
         judge_byte(b);
         if (eos) flush_held();
         if (step_q.size() > 0) begin
            step_q[step_q.size()-1].end_of_run  = 1'b1;
            step_q[step_q.size()-1].string_done = eos;
         end
         foreach (step_q[i]) pending_q.push_back(step_q[i]);
      endfunction

      function void check_result(logic [7:0] data, logic [1:0] user, logic last);
         utf8_result_type exp_r;
         utf8_result_type got;
         got.out_byte     = data;
         got.was_replaced = user[0];
         got.end_of_run   = last;
         got.string_done  = user[1];
         checked++;
         if (user[0]) replaced_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] unexpected result: byte %02h repl %b run_end %b done %b",
                        $realtime, data, user[0], last, user[1]);
            return;
         end
         exp_r = pending_q.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("[%0t] mismatch: expected byte %02h repl %b run_end %b done %b",
                        $realtime, exp_r.out_byte, exp_r.was_replaced, exp_r.end_of_run,
                        exp_r.string_done);
               $display("          got byte %02h repl %b run_end %b done %b",
                        data, user[0], last, user[1]);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;     // [7:0] in_byte
   logic         req_tlast;     // end_of_string
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;     // [7:0] out_byte
   logic [1:0]   rsp_tuser;     // [0] was_replaced, [1] string_done
   logic         rsp_tlast;     // end_of_run
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   utf8_expect_board board;
   int           items_sent;
   int           strings_sent;
   int           burst_left;
   int           settings_used;

   utf8_validate_replace DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Receiver: switch at random between stall patterns
   int rx_mode;
   int rx_count;
   int rx_stall;
   always @(negedge clock) begin
      if (rx_count % 50 == 0) rx_mode = $urandom_range(0, 3);
      rx_count++;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (rx_count % 4 == 0);
         default: begin
            if (rx_stall > 0) begin
               rx_stall--;
               rsp_tready <= 1'b0;
            end else begin
               if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 12);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // Check each result item as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Hard stop if the run hangs
   int cycle_count;
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_validate_replace verification failed");
      $finish;
   end

   // Send one byte in bursts with random gaps between them
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      board.note_item(b, eos);
      items_sent++;
   endtask

   task automatic send_string(input byte_q_type s);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
      strings_sent++;
   endtask

   // Build a random string: mostly ASCII and well-formed characters, some noise
   task automatic make_string(output byte_q_type s);
      byte_q_type ch;
      int         target;
      int         kind;
      int         len;
      int         k;
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      s = {};
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      while (s.size() < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            s.push_back(8'($urandom_range(0, 127)));
         end else if (kind == 7) begin
            s.push_back(8'($urandom_range(0, 255)));
         end else begin
            // favour the leads whose second byte range is narrowed
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 3))
                  0:       lead = 8'hE0;
                  1:       lead = 8'hED;
                  2:       lead = 8'hF0;
                  default: lead = 8'hF4;
               endcase
            end else begin
               case ($urandom_range(2, 4))
                  2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
                  3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                  default: lead = 8'($urandom_range(8'hF0, 8'hF4));
               endcase
            end
            len = (lead < 8'hE0) ? 2 : (lead < 8'hF0) ? 3 : 4;
            ch = {lead};
            for (k = 1; k < len; k++) begin
               lo = 8'h80;
               hi = 8'hBF;
               if (k == 1) begin
                  if (lead == 8'hE0) lo = 8'hA0;
                  else if (lead == 8'hED) hi = 8'h9F;
                  else if (lead == 8'hF0) lo = 8'h90;
                  else if (lead == 8'hF4) hi = 8'h8F;
               end
               ch.push_back(8'($urandom_range(lo, hi)));
            end
            // break some sequences: cut short, or spoil one continuation
            if (kind == 8) begin
               ch = ch[0:$urandom_range(0, len - 2)];
            end else if (kind == 9) begin
               k = $urandom_range(1, len - 1);
               ch[k] = 8'($urandom_range(0, 255));
            end
            s = {s, ch};
         end
      end
   endtask

   // Register write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.apply_write(addr, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Hold the sender until every expected item is out and the block is quiet
   task automatic wait_idle(input int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic run_random_phase();
      byte_q_type s;
      int         phase_start;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
         make_string(s);
         send_string(s);
      end
   endtask

   initial begin
      board         = new();
      items_sent    = 0;
      strings_sent  = 0;
      burst_left    = 0;
      settings_used = 1;
      rx_mode       = 0;
      rx_count      = 0;
      rx_stall      = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = 3'd0;
      csr_pwdata    = 32'h0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero and top ASCII, two-byte range edges
      send_string('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF});
      // Narrowed second bytes after E0 and ED, then E0 failing on a low second byte
      send_string('{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF, 8'hE0, 8'h9F});
      // Four-byte edges, then F0, ED and F4 failing on out-of-range second bytes
      send_string('{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                    8'hF0, 8'h8F, 8'hED, 8'hA0, 8'hF4, 8'h90});
      // Invalid leads, stray continuation, failed pair retried as ASCII,
      // and an open sequence flushed at the end of the string
      send_string('{8'hC0, 8'hC1, 8'hF5, 8'hFF, 8'h80, 8'hC3, 8'h41, 8'hE1, 8'h80});
      // Lone lead byte as a whole string
      send_string('{8'hF1});

      // Random strings under the reset value, then the extremes and one more
      run_random_phase();
      wait_idle(SETTLE_CYCLES);
      csr_write(REPL_ADDR, 32'h0000_0000);
      settings_used++;
      run_random_phase();
      wait_idle(SETTLE_CYCLES);
      csr_write(REPL_ADDR, 32'h0000_00FF);
      settings_used++;
      run_random_phase();
      wait_idle(SETTLE_CYCLES);
      // upper bits must be dropped; the unmapped address must change nothing
      csr_write(REPL_ADDR, 32'hDEAD_BE5A);
      csr_write(SPARE_ADDR, 32'h0000_0011);
      settings_used++;
      run_random_phase();

      wait_idle(DRAIN_CYCLES);

      $display("Covered %0d strings, %0d input items, %0d result items (%0d replaced)",
               strings_sent, items_sent, board.checked, board.replaced_seen);
      $display("Replacement byte settings used: %0d, mismatches: %0d, left waiting: %0d",
               settings_used, board.mismatches, board.pending_q.size());
      if (board.mismatches == 0 && board.pending_q.size() == 0) begin
         $display("utf8_validate_replace verification clean");
      end else begin
         $display("utf8_validate_replace verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/utf8vr_pkg.sv
sv/utf8vr_front.sv
sv/utf8vr_queue.sv
sv/utf8vr_back.sv
sv/utf8_validate_replace.sv
verif/tb_utf8_validate_replace.sv
